// ===== design/tmi_pkg.sv =====
// ----------------------------------------------------------------------------
// tmi_pkg
// Shared types and constants for the trapezoid motion integrator.
// ----------------------------------------------------------------------------
package tmi_pkg;

  localparam int ACCEL_WIDTH_DEF    = 16;
  localparam int VELOCITY_WIDTH_DEF = 48;
  localparam int POSITION_WIDTH_DEF = 64;

  localparam int TS_W     = 32;   // timestamp width
  localparam int DT_W     = 16;   // clamped elapsed time width
  localparam int THR_W    = 15;   // threshold register width
  localparam int CHUNK_W  = 32;   // low slice of the position multiply
  localparam int MUL_A_W  = 34;   // shared multiplier, signed operand
  localparam int MUL_B_W  = DT_W + 1;
  localparam int MUL_P_W  = MUL_A_W + MUL_B_W;

  localparam int NUM_AXES = 3;
  localparam int AX_W     = 2;
  localparam logic [AX_W-1:0] LAST_AX = AX_W'(NUM_AXES - 1);

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(15);

  typedef enum logic [2:0] {
    OP_NONE = 3'd0,
    OP_DV   = 3'd1,
    OP_VEL  = 3'd2,
    OP_VV   = 3'd3,
    OP_PLO  = 3'd4,
    OP_PHI  = 3'd5,
    OP_DP   = 3'd6,
    OP_POS  = 3'd7
  } op_t;

  typedef struct packed {
    logic            accept;
    op_t             op;
    logic [AX_W-1:0] ax;
    logic            load_out;
  } tmi_cmd_t;

endpackage

// ===== design/trapezoid_motion_integrator_unit.sv =====
// ----------------------------------------------------------------------------
// trapezoid_motion_integrator_unit
// Three-axis trapezoidal dead-reckoning integrator with saturating sums.
//
//   channel | ports                              | dir | transaction
//   --------+------------------------------------+-----+---------------------
//   in      | in_valid/in_ready, in_accel_*, ts  | in  | one IMU sample
//   out     | out_valid/out_ready, vel/pos/flags | out | one motion state
//   cfg     | cfg_valid/cfg_ready, threshold     | in  | threshold write
//
// An integrating sample is accepted, then each axis in turn steps through DV,
// VEL, VV, PLO, PHI, DP and POS on the shared multiplier and adders, then the
// output register is loaded. A sample below threshold skips the axis steps.
// Synchronous active-low reset clears all motion state; threshold resets to 15.
// The output register lets a new sample be accepted while a result waits;
// the sequencer holds only if it finishes again before that result is taken.
// ----------------------------------------------------------------------------
module trapezoid_motion_integrator_unit #(
  parameter int ACCEL_WIDTH    = tmi_pkg::ACCEL_WIDTH_DEF,
  parameter int VELOCITY_WIDTH = tmi_pkg::VELOCITY_WIDTH_DEF,
  parameter int POSITION_WIDTH = tmi_pkg::POSITION_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic signed [ACCEL_WIDTH-1:0]    in_accel_x,
  input  logic signed [ACCEL_WIDTH-1:0]    in_accel_y,
  input  logic signed [ACCEL_WIDTH-1:0]    in_accel_z,
  input  logic [tmi_pkg::TS_W-1:0]         in_timestamp_ms,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [VELOCITY_WIDTH-1:0] out_vel_x,
  output logic signed [VELOCITY_WIDTH-1:0] out_vel_y,
  output logic signed [VELOCITY_WIDTH-1:0] out_vel_z,
  output logic signed [POSITION_WIDTH-1:0] out_pos_x,
  output logic signed [POSITION_WIDTH-1:0] out_pos_y,
  output logic signed [POSITION_WIDTH-1:0] out_pos_z,
  output logic                             out_updated,
  output logic                             out_saturated,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tmi_pkg::THR_W-1:0]        cfg_accel_threshold
);
  import tmi_pkg::*;

  tmi_cmd_t cmd;
  logic     pass;

  assign cfg_ready = 1'b1;

  tmi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .pass      (pass),
    .cmd       (cmd)
  );

  tmi_datapath #(
    .ACCEL_WIDTH    (ACCEL_WIDTH),
    .VELOCITY_WIDTH (VELOCITY_WIDTH),
    .POSITION_WIDTH (POSITION_WIDTH)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .pass            (pass),
    .cfg_we          (cfg_valid & cfg_ready),
    .cfg_data        (cfg_accel_threshold),
    .in_accel_x      (in_accel_x),
    .in_accel_y      (in_accel_y),
    .in_accel_z      (in_accel_z),
    .in_timestamp_ms (in_timestamp_ms),
    .out_vel_x       (out_vel_x),
    .out_vel_y       (out_vel_y),
    .out_vel_z       (out_vel_z),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_pos_z       (out_pos_z),
    .out_updated     (out_updated),
    .out_saturated   (out_saturated)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted while a sample is in progress");

  a_no_clip_without_update: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_updated) |-> !out_saturated)
    else $error("saturation flagged on a sample that did not integrate");

  a_axis_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op != OP_NONE) |-> (cmd.ax != 2'd3 && !in_ready))
    else $error("datapath operation with bad axis or while idle");

endmodule

// ===== design/tmi_ctrl.sv =====
// ----------------------------------------------------------------------------
// tmi_ctrl
// Sequencer: accepts a sample, steps the shared datapath through three axes
// if it passes the threshold, then hands the result to the output register.
// ----------------------------------------------------------------------------
module tmi_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              out_ready,
  output logic              out_valid,
  input  logic              pass,
  output tmi_pkg::tmi_cmd_t cmd
);
  import tmi_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_DV   = 9'b000000010,
    S_VEL  = 9'b000000100,
    S_VV   = 9'b000001000,
    S_PLO  = 9'b000010000,
    S_PHI  = 9'b000100000,
    S_DP   = 9'b001000000,
    S_POS  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t          state_r, state_nxt;
  logic [AX_W-1:0] ax_r, ax_nxt;
  logic            out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt    = state_r;
    ax_nxt       = ax_r;
    cmd          = '0;
    cmd.op       = OP_NONE;
    cmd.ax       = ax_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          ax_nxt     = '0;
          state_nxt  = pass ? S_DV : S_DONE;
        end
      end
      S_DV: begin
        cmd.op    = OP_DV;
        state_nxt = S_VEL;
      end
      S_VEL: begin
        cmd.op    = OP_VEL;
        state_nxt = S_VV;
      end
      S_VV: begin
        cmd.op    = OP_VV;
        state_nxt = S_PLO;
      end
      S_PLO: begin
        cmd.op    = OP_PLO;
        state_nxt = S_PHI;
      end
      S_PHI: begin
        cmd.op    = OP_PHI;
        state_nxt = S_DP;
      end
      S_DP: begin
        cmd.op    = OP_DP;
        state_nxt = S_POS;
      end
      S_POS: begin
        cmd.op = OP_POS;
        if (ax_r == LAST_AX) begin
          state_nxt = S_DONE;
        end else begin
          ax_nxt    = ax_r + 1'b1;
          state_nxt = S_DV;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = cmd.load_out | (out_valid_r & ~out_ready);
  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ax_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ax_r        <= ax_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== design/tmi_datapath.sv =====
// ----------------------------------------------------------------------------
// tmi_datapath
// Motion state, one shared 34x17 multiplier, saturating adders and the
// output register.
// ----------------------------------------------------------------------------
module tmi_datapath #(
  parameter int ACCEL_WIDTH    = tmi_pkg::ACCEL_WIDTH_DEF,
  parameter int VELOCITY_WIDTH = tmi_pkg::VELOCITY_WIDTH_DEF,
  parameter int POSITION_WIDTH = tmi_pkg::POSITION_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tmi_pkg::tmi_cmd_t                cmd,
  output logic                             pass,
  input  logic                             cfg_we,
  input  logic [tmi_pkg::THR_W-1:0]        cfg_data,
  input  logic signed [ACCEL_WIDTH-1:0]    in_accel_x,
  input  logic signed [ACCEL_WIDTH-1:0]    in_accel_y,
  input  logic signed [ACCEL_WIDTH-1:0]    in_accel_z,
  input  logic [tmi_pkg::TS_W-1:0]         in_timestamp_ms,
  output logic signed [VELOCITY_WIDTH-1:0] out_vel_x,
  output logic signed [VELOCITY_WIDTH-1:0] out_vel_y,
  output logic signed [VELOCITY_WIDTH-1:0] out_vel_z,
  output logic signed [POSITION_WIDTH-1:0] out_pos_x,
  output logic signed [POSITION_WIDTH-1:0] out_pos_y,
  output logic signed [POSITION_WIDTH-1:0] out_pos_z,
  output logic                             out_updated,
  output logic                             out_saturated
);
  import tmi_pkg::*;

  localparam int A     = ACCEL_WIDTH;
  localparam int V     = VELOCITY_WIDTH;
  localparam int P     = POSITION_WIDTH;
  localparam int CMP_W = (A + 1 > THR_W) ? A + 1 : THR_W;
  localparam int DV_W  = A + DT_W + 1;
  localparam int VS_W  = ((V > DV_W) ? V : DV_W) + 1;
  localparam int VV_W  = V + 1;
  localparam int PLO_W = CHUNK_W + DT_W;
  localparam int DP_W  = V + DT_W + 1;
  localparam int PS_W  = ((P > DP_W) ? P : DP_W) + 1;

  // architectural state
  logic [THR_W-1:0]   thr_r;
  logic [TS_W-1:0]    last_time_r;
  logic signed [A-1:0] prev_r [NUM_AXES];
  logic signed [V-1:0] vel_r  [NUM_AXES];
  logic signed [P-1:0] pos_r  [NUM_AXES];
  logic               upd_r;
  logic               clip_r;

  // working registers
  logic [DT_W-1:0]          dt_r;
  logic signed [A-1:0]      acc_r [NUM_AXES];
  logic signed [MUL_P_W-1:0] prod_r;
  logic signed [V-1:0]      vnew_r;
  logic signed [VV_W-1:0]   vv_r;
  logic [PLO_W-1:0]         plo_r;
  logic signed [DP_W-1:0]   dp_r;

  // elapsed time and threshold test
  logic [TS_W-1:0] diff;
  logic [DT_W-1:0] dt_c;
  logic [A:0]      ax_ext;
  logic [A:0]      mag;

  assign diff   = in_timestamp_ms - last_time_r;
  assign dt_c   = (|diff[TS_W-1:DT_W]) ? {DT_W{1'b1}} : diff[DT_W-1:0];
  assign ax_ext = {in_accel_x[A-1], in_accel_x};
  assign mag    = in_accel_x[A-1] ? (~ax_ext + 1'b1) : ax_ext;
  assign pass   = CMP_W'(mag) > CMP_W'(thr_r);

  // per-axis operands
  logic signed [A-1:0] acc_cur, prev_cur;
  logic signed [V-1:0] vel_cur;
  logic signed [P-1:0] pos_cur;
  logic signed [A:0]   asum;

  assign acc_cur  = acc_r[cmd.ax];
  assign prev_cur = prev_r[cmd.ax];
  assign vel_cur  = vel_r[cmd.ax];
  assign pos_cur  = pos_r[cmd.ax];
  assign asum     = {prev_cur[A-1], prev_cur} + {acc_cur[A-1], acc_cur};

  // shared multiplier
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [MUL_P_W-1:0] prod_c;
  logic signed [VV_W-CHUNK_W-1:0] vv_hi;

  assign vv_hi = vv_r[VV_W-1:CHUNK_W];

  always_comb begin
    case (cmd.op)
      OP_DV:   mul_a = MUL_A_W'(asum);
      OP_PLO:  mul_a = {{(MUL_A_W-CHUNK_W){1'b0}}, vv_r[CHUNK_W-1:0]};
      OP_PHI:  mul_a = MUL_A_W'(vv_hi);
      default: mul_a = '0;
    endcase
  end

  assign mul_b  = {1'b0, dt_r};
  assign prod_c = mul_a * mul_b;

  // velocity sum with saturation
  logic signed [DV_W-1:0] dv;
  logic signed [VS_W-1:0] vsum;
  logic                   vfit;
  logic signed [V-1:0]    vsat;

  assign dv   = prod_r[DV_W-1:0];
  assign vsum = VS_W'(vel_cur) + VS_W'(dv);
  assign vfit = (vsum[VS_W-1:V-1] == {(VS_W-V+1){vsum[VS_W-1]}});
  assign vsat = vfit ? vsum[V-1:0]
              : (vsum[VS_W-1] ? {1'b1, {(V-1){1'b0}}} : {1'b0, {(V-1){1'b1}}});

  // position delta and sum with saturation
  logic signed [VV_W-1:0] vv_c;
  logic [DP_W-1:0]        dp_c;
  logic signed [PS_W-1:0] psum;
  logic                   pfit;
  logic signed [P-1:0]    psat;

  assign vv_c = VV_W'(vel_cur) + VV_W'(vnew_r);
  assign dp_c = {prod_r[DP_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}} + DP_W'(plo_r);
  assign psum = PS_W'(pos_cur) + PS_W'(dp_r);
  assign pfit = (psum[PS_W-1:P-1] == {(PS_W-P+1){psum[PS_W-1]}});
  assign psat = pfit ? psum[P-1:0]
              : (psum[PS_W-1] ? {1'b1, {(P-1){1'b0}}} : {1'b0, {(P-1){1'b1}}});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r       <= THR_RESET;
      last_time_r <= '0;
      upd_r       <= 1'b0;
      clip_r      <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        prev_r[i] <= '0;
        vel_r[i]  <= '0;
        pos_r[i]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        thr_r <= cfg_data;
      end
      if (cmd.accept) begin
        last_time_r <= in_timestamp_ms;
        upd_r       <= pass;
        clip_r      <= 1'b0;
      end
      case (cmd.op)
        OP_VEL: begin
          if (!vfit) clip_r <= 1'b1;
        end
        OP_POS: begin
          if (!pfit) clip_r <= 1'b1;
          pos_r[cmd.ax]  <= psat;
          vel_r[cmd.ax]  <= vnew_r;
          prev_r[cmd.ax] <= acc_cur;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dt_r     <= dt_c;
      acc_r[0] <= in_accel_x;
      acc_r[1] <= in_accel_y;
      acc_r[2] <= in_accel_z;
    end
    case (cmd.op)
      OP_DV:  prod_r <= prod_c;
      OP_VEL: vnew_r <= vsat;
      OP_VV:  vv_r   <= vv_c;
      OP_PLO: prod_r <= prod_c;
      OP_PHI: begin
        plo_r  <= prod_r[PLO_W-1:0];
        prod_r <= prod_c;
      end
      OP_DP:  dp_r   <= dp_c;
      default: begin
      end
    endcase
    if (cmd.load_out) begin
      out_vel_x     <= vel_r[0];
      out_vel_y     <= vel_r[1];
      out_vel_z     <= vel_r[2];
      out_pos_x     <= pos_r[0];
      out_pos_y     <= pos_r[1];
      out_pos_z     <= pos_r[2];
      out_updated   <= upd_r;
      out_saturated <= clip_r;
    end
  end

endmodule
